FILE: rtl/stl_pkg.sv
// shared widths and result types for the source text lexer
// no dependencies; compiled first
package stl_pkg;

    // counter widths
    localparam int POS_BITS   = 16;
    localparam int LINE_BITS  = 16;
    localparam int FIELD_BITS = 16;

    // most tokens one source byte can complete
    localparam int MAX_RESULTS = 3;

    // one token as delivered on the result channel
    typedef struct packed {
        logic [4:0]            kind;
        logic [1:0]            err;
        logic [FIELD_BITS-1:0] offset;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
    } t_result;

    // everything one scanned byte produces
    typedef struct packed {
        logic [1:0]                  count;
        t_result [MAX_RESULTS-1:0]   res;
    } t_step;

endpackage

FILE: rtl/stl_stream_if.sv
// valid/ready channel interfaces for the lexer input bytes and output tokens
// depends on stl_pkg for the field widths
interface stl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_source;

    modport source (output valid, output char_in, output end_of_source, input ready);
    modport sink   (input valid, input char_in, input end_of_source, output ready);
endinterface

interface stl_token_if;
    logic                          valid;
    logic                          ready;
    logic [4:0]                    token_kind;
    logic [1:0]                    error_kind;
    logic [stl_pkg::FIELD_BITS-1:0] token_offset;
    logic [stl_pkg::FIELD_BITS-1:0] token_length;
    logic [stl_pkg::FIELD_BITS-1:0] line_number;
    logic                          last_of_run;

    modport source (output valid, output token_kind, output error_kind, output token_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input error_kind, input token_offset,
                    input token_length, input line_number, input last_of_run,
                    output ready);
endinterface

FILE: rtl/source_text_lexer_core.sv
// Source text lexer: one byte per transaction in, tokens out.
// An accepted byte goes through the input register and then the result buffer to the output.
// Throughput: 1 byte per cycle while the sink is ready and each byte completes at most one
//   token; a byte that completes more (up to 3) holds the input register while they drain.
// Reset (synchronous, active low): scanner idle, position 0, line 1, no tokens pending.
module source_text_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stl_char_if.sink    i_src,
    stl_token_if.source o_res
);
    import stl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eos;
    logic       free;
    logic       fire;
    t_step      step;

    assign fire        = r_in_valid && free;
    assign i_src.ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.ready) begin
            r_in_valid <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_char <= i_src.char_in;
            r_eos  <= i_src.end_of_source;
        end
    end

    // token decode and counters
    stl_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_char),
        .i_eos   (r_eos),
        .o_step  (step)
    );

    // token buffer and output channel
    stl_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_step  (step),
        .o_free  (free),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/stl_scanner.sv
// scanner core: mode register, position and line counters, and the
// per-byte token decode; depends on stl_pkg
module stl_scanner (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_char,
    input  logic             i_eos,
    output stl_pkg::t_step   o_step
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_NUMDOT, M_FRAC, M_SLASH, M_COMMENT, M_OP, M_STR
    } t_mode;

    // token kinds
    localparam logic [4:0] K_LPAREN = 5'd0;
    localparam logic [4:0] K_RPAREN = 5'd1;
    localparam logic [4:0] K_LBRACE = 5'd2;
    localparam logic [4:0] K_RBRACE = 5'd3;
    localparam logic [4:0] K_SEMI   = 5'd4;
    localparam logic [4:0] K_COMMA  = 5'd5;
    localparam logic [4:0] K_DOT    = 5'd6;
    localparam logic [4:0] K_PLUS   = 5'd8;
    localparam logic [4:0] K_SLASH  = 5'd9;
    localparam logic [4:0] K_STAR   = 5'd10;
    localparam logic [4:0] K_BANG   = 5'd11;
    localparam logic [4:0] K_ASSIGN = 5'd13;
    localparam logic [4:0] K_LESS   = 5'd15;
    localparam logic [4:0] K_MORE   = 5'd17;
    localparam logic [4:0] K_IDENT  = 5'd19;
    localparam logic [4:0] K_STRING = 5'd20;
    localparam logic [4:0] K_NUMBER = 5'd21;
    localparam logic [4:0] K_EOF    = 5'd22;
    localparam logic [4:0] K_ERROR  = 5'd23;

    // error codes
    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    // characters
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_MORE   = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam int                   WIDE_BITS = 33;
    localparam logic [POS_BITS-1:0]  POS_MAX   = {POS_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [WIDE_BITS-1:0] FIELD_MAX = WIDE_BITS'({FIELD_BITS{1'b1}});

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_MINUS);
    endfunction

    function automatic logic [FIELD_BITS-1:0] clamp(input logic [WIDE_BITS-1:0] v);
        return (v > FIELD_MAX) ? {FIELD_BITS{1'b1}} : v[FIELD_BITS-1:0];
    endfunction

    // operator kind from the pending first character
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            CH_BANG: k = K_BANG;
            CH_EQ:   k = K_ASSIGN;
            CH_LESS: k = K_LESS;
            default: k = K_MORE;
        endcase
        return k;
    endfunction

    t_mode                  r_mode;
    logic [7:0]             r_pend;
    logic [POS_BITS-1:0]    r_start;
    logic [POS_BITS-1:0]    r_pos;
    logic [LINE_BITS-1:0]   r_line;

    t_mode                  n_mode;
    logic [7:0]             n_pend;
    logic [POS_BITS-1:0]    n_start;
    logic [POS_BITS-1:0]    n_pos;
    logic [LINE_BITS-1:0]   n_line;

    logic [POS_BITS:0]      pos_ext;
    logic [POS_BITS:0]      start_ext;
    logic [POS_BITS:0]      dot_ext;
    logic [POS_BITS:0]      len_pos;
    logic [POS_BITS:0]      len_dot;
    logic [POS_BITS:0]      len_str;
    logic [FIELD_BITS-1:0]  line_f;
    t_result                res_ident;
    t_result                res_number;
    t_result                res_num_dot;
    t_result                res_dot;
    t_result                res_slash;
    t_result                res_op1;
    t_result                res_op2;
    t_result                res_str_err;
    t_result                res_string;
    t_result                res_eof;

    // start-of-token decode
    t_mode                  sc_mode;
    logic                   sc_load;
    logic                   sc_op;
    logic                   sc_bump;
    logic                   sc_emit;
    t_result                sc_res;

    logic                   do_start;
    logic                   bump;
    logic [1:0]             cnt;
    t_result [MAX_RESULTS-1:0] res;

    // offsets and lengths of the candidate tokens
    always_comb begin
        pos_ext   = {1'b0, r_pos};
        start_ext = {1'b0, r_start};
        dot_ext   = (r_pos != '0) ? pos_ext - 1'b1 : '0;
        len_pos   = (pos_ext >= start_ext) ? pos_ext - start_ext : '0;
        len_dot   = (dot_ext >= start_ext) ? dot_ext - start_ext : '0;
        len_str   = (pos_ext + 1'b1 >= start_ext) ? pos_ext + 1'b1 - start_ext : '0;
        line_f    = clamp(WIDE_BITS'(r_line));

        res_ident   = '{K_IDENT, E_NONE, clamp(WIDE_BITS'(r_start)),
                        clamp(WIDE_BITS'(len_pos)), line_f};
        res_number  = '{K_NUMBER, E_NONE, clamp(WIDE_BITS'(r_start)),
                        clamp(WIDE_BITS'(len_pos)), line_f};
        res_num_dot = '{K_NUMBER, E_NONE, clamp(WIDE_BITS'(r_start)),
                        clamp(WIDE_BITS'(len_dot)), line_f};
        res_dot     = '{K_DOT, E_NONE, clamp(WIDE_BITS'(dot_ext)), FIELD_BITS'(1), line_f};
        res_slash   = '{K_SLASH, E_NONE, clamp(WIDE_BITS'(r_start)), FIELD_BITS'(1), line_f};
        res_op1     = '{op_kind(r_pend), E_NONE, clamp(WIDE_BITS'(r_start)),
                        FIELD_BITS'(1), line_f};
        res_op2     = '{op_kind(r_pend) + 5'd1, E_NONE, clamp(WIDE_BITS'(r_start)),
                        FIELD_BITS'(2), line_f};
        res_str_err = '{K_ERROR, E_UNTERM, clamp(WIDE_BITS'(r_start)),
                        clamp(WIDE_BITS'(len_pos)), line_f};
        res_string  = '{K_STRING, E_NONE, clamp(WIDE_BITS'(r_start)),
                        clamp(WIDE_BITS'(len_str)), line_f};
        res_eof     = '{K_EOF, E_NONE, clamp(WIDE_BITS'(r_pos)), '0, line_f};
    end

    // what a byte does when it opens a new token
    always_comb begin
        sc_mode = M_IDLE;
        sc_load = 1'b0;
        sc_op   = 1'b0;
        sc_bump = 1'b0;
        sc_emit = 1'b1;
        sc_res  = '{K_ERROR, E_UNEXPECTED, clamp(WIDE_BITS'(r_pos)), FIELD_BITS'(1), line_f};
        priority if (i_char == CH_SPACE || i_char == CH_CR || i_char == CH_TAB) begin
            sc_emit = 1'b0;
        end else if (i_char == CH_NL) begin
            sc_emit = 1'b0;
            sc_bump = 1'b1;
        end else if (is_alpha(i_char)) begin
            sc_emit = 1'b0;
            sc_load = 1'b1;
            sc_mode = M_IDENT;
        end else if (is_digit(i_char)) begin
            sc_emit = 1'b0;
            sc_load = 1'b1;
            sc_mode = M_INT;
        end else if (i_char == CH_SLASH) begin
            sc_emit = 1'b0;
            sc_load = 1'b1;
            sc_mode = M_SLASH;
        end else if (i_char == CH_QUOTE) begin
            sc_emit = 1'b0;
            sc_load = 1'b1;
            sc_mode = M_STR;
        end else if (i_char == CH_BANG || i_char == CH_EQ || i_char == CH_LESS
                     || i_char == CH_MORE) begin
            sc_emit = 1'b0;
            sc_load = 1'b1;
            sc_op   = 1'b1;
            sc_mode = M_OP;
        end else begin
            unique case (i_char)
                CH_LPAREN: sc_res.kind = K_LPAREN;
                CH_RPAREN: sc_res.kind = K_RPAREN;
                CH_LBRACE: sc_res.kind = K_LBRACE;
                CH_RBRACE: sc_res.kind = K_RBRACE;
                CH_SEMI:   sc_res.kind = K_SEMI;
                CH_COMMA:  sc_res.kind = K_COMMA;
                CH_DOT:    sc_res.kind = K_DOT;
                CH_PLUS:   sc_res.kind = K_PLUS;
                CH_STAR:   sc_res.kind = K_STAR;
                default:   sc_res.kind = K_ERROR;
            endcase
            if (sc_res.kind != K_ERROR) begin
                sc_res.err = E_NONE;
            end
        end
    end

    // per-byte mode transition and token list
    always_comb begin
        n_mode   = r_mode;
        do_start = 1'b0;
        bump     = 1'b0;
        cnt      = '0;
        res      = '0;
        if (i_eos) begin
            unique case (r_mode)
                M_IDENT: begin
                    res[0] = res_ident;
                    cnt    = 2'd1;
                end
                M_INT, M_FRAC: begin
                    res[0] = res_number;
                    cnt    = 2'd1;
                end
                M_NUMDOT: begin
                    res[0] = res_num_dot;
                    res[1] = res_dot;
                    cnt    = 2'd2;
                end
                M_SLASH: begin
                    res[0] = res_slash;
                    cnt    = 2'd1;
                end
                M_OP: begin
                    res[0] = res_op1;
                    cnt    = 2'd1;
                end
                M_STR: begin
                    res[0] = res_str_err;
                    cnt    = 2'd1;
                end
                default: cnt = '0;
            endcase
            res[cnt] = res_eof;
            cnt      = cnt + 2'd1;
            n_mode   = M_IDLE;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (!(is_alpha(i_char) || is_digit(i_char))) begin
                        res[0]   = res_ident;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_INT: begin
                    if (i_char == CH_DOT) begin
                        n_mode = M_NUMDOT;
                    end else if (!is_digit(i_char)) begin
                        res[0]   = res_number;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(i_char)) begin
                        n_mode = M_FRAC;
                    end else begin
                        res[0]   = res_num_dot;
                        res[1]   = res_dot;
                        cnt      = 2'd2;
                        do_start = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(i_char)) begin
                        res[0]   = res_number;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_char == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        res[0]   = res_slash;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_char == CH_NL) begin
                        bump   = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_OP: begin
                    if (i_char == CH_EQ) begin
                        res[0] = res_op2;
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0]   = res_op1;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (i_char == CH_QUOTE) begin
                        res[0] = res_string;
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else if (i_char == CH_NL) begin
                        bump = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
            if (do_start) begin
                n_mode = sc_mode;
                bump   = sc_bump;
                if (sc_emit) begin
                    res[cnt] = sc_res;
                    cnt      = cnt + 2'd1;
                end
            end
        end

        n_start = (do_start && sc_load) ? r_pos : r_start;
        n_pend  = (do_start && sc_op) ? i_char : r_pend;
        n_pos   = (!i_eos && r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_line  = (bump && r_line != LINE_MAX) ? r_line + 1'b1 : r_line;
    end

    assign o_step = '{count: cnt, res: res};

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pend   <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_line   <= LINE_BITS'(1);
        end else begin
            if (i_fire) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_line  <= n_line;
            end
        end
    end

    // an open token never starts past the current position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_IDLE) |-> (r_start <= r_pos))
        else $error("token start beyond byte position");

    // a consumed end mark always leaves the scanner idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eos) |=> (r_mode == M_IDLE))
        else $error("scanner not idle after end of source");

    // line counter never drops below one and only moves on a consumed byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != '0) && ($past(i_fire) || $stable(r_line)))
        else $error("line counter corrupted");

endmodule

FILE: rtl/stl_res_queue.sv
// result buffer: holds the tokens of one scanned byte and hands them out
// one transaction at a time; depends on stl_pkg and stl_stream_if
module stl_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stl_pkg::t_step   i_step,
    output logic             o_free,
    stl_token_if.source      o_res
);
    import stl_pkg::*;

    t_result [MAX_RESULTS-1:0] r_slot;
    logic [1:0]                r_cnt;
    logic [1:0]                r_idx;
    logic [1:0]                idx_inc;
    logic                      out_fire;
    t_result                   cur;

    assign idx_inc  = r_idx + 2'd1;
    assign out_fire = o_res.valid && o_res.ready;
    assign o_free   = (r_idx == r_cnt) || (out_fire && idx_inc == r_cnt);

    // output view of the current slot
    assign cur                = r_slot[r_idx];
    assign o_res.valid        = (r_idx != r_cnt);
    assign o_res.token_kind   = cur.kind;
    assign o_res.error_kind   = cur.err;
    assign o_res.token_offset = cur.offset;
    assign o_res.token_length = cur.length;
    assign o_res.line_number  = cur.line;
    assign o_res.last_of_run  = (idx_inc == r_cnt);

    // load a new run or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_step.count;
            r_idx <= '0;
        end else if (out_fire) begin
            r_idx <= idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_step.res;
        end
    end

    // read pointer stays within the loaded run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("result pointer past run");

    // a new run is loaded only once the previous one is drained
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!o_res.valid || (out_fire && o_res.last_of_run)))
        else $error("result run overwritten");

    // a loaded non-empty run shows up on the output next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_step.count != 2'd0) |=> (o_res.valid && r_idx == 2'd0))
        else $error("loaded run not presented");

endmodule

FILE: verif/tb_source_text_lexer_core.sv
// testbench for source_text_lexer_core: directed and random source text, token scoreboard
// depends on stl_pkg and the stl_char_if / stl_token_if channel interfaces
module tb_source_text_lexer_core;
    import stl_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 130;
    localparam int LONG_HOLD     = 300;

    localparam longint unsigned FIELD_MAX = (longint'(1) << FIELD_BITS) - 1;

    // token kinds as they appear on the result channel
    typedef enum logic [4:0] {
        TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_COMMA, TK_DOT,
        TK_MINUS, TK_PLUS, TK_SLASH, TK_STAR,
        TK_BANG, TK_BANG_EQ, TK_EQ, TK_EQ_EQ, TK_LESS, TK_LESS_EQ,
        TK_GREATER, TK_GREATER_EQ,
        TK_IDENT, TK_STRING, TK_NUMBER, TK_EOF, TK_ERROR
    } t_token_kind;

    typedef enum logic [1:0] {LEX_OK, LEX_BAD_CHAR, LEX_OPEN_STRING} t_lex_error;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_NUMDOT, SCAN_FRAC,
        SCAN_SLASH, SCAN_COMMENT, SCAN_OP, SCAN_STR
    } t_scan_mode;

    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-";
    localparam string WORD_CHARS = "abcxyzQRZ-0123456789";
    localparam string DIGITS  = "0123456789";
    localparam string PUNCT   = "(){};,.+*/";
    localparam string OPS     = "!=<>";

    typedef struct packed {
        t_result tok;
        logic    last;
    } t_token_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stl_char_if  src_if();
    stl_token_if tok_if();

    source_text_lexer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_res   (tok_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // scanner state mirrored by the predictor
    t_scan_mode           scan_mode_q = SCAN_IDLE;
    logic [7:0]           op_char_q   = '0;
    logic [POS_BITS-1:0]  tok_start_q = '0;
    logic [POS_BITS-1:0]  byte_pos_q  = '0;
    logic [LINE_BITS-1:0] line_q      = LINE_BITS'(1);

    t_token_exp step_tokens[$];
    t_token_exp expected_tokens[$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  bytes_sent    = 0;
    bit  quiet_source  = 0;
    bit  quiet_sink    = 0;
    bit  sink_hold_req = 0;

    function automatic logic [FIELD_BITS-1:0] clamp_field(longint unsigned v);
        return (v > FIELD_MAX) ? FIELD_MAX[FIELD_BITS-1:0] : v[FIELD_BITS-1:0];
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_MINUS;
    endfunction

    function automatic longint unsigned span_to(longint unsigned end_pos);
        return (end_pos >= tok_start_q) ? end_pos - tok_start_q : 0;
    endfunction

    function automatic t_token_kind op_single(logic [7:0] c);
        case (c)
            "!":     return TK_BANG;
            "=":     return TK_EQ;
            "<":     return TK_LESS;
            default: return TK_GREATER;
        endcase
    endfunction

    function automatic void bump_line();
        if (line_q != '1) line_q = line_q + 1'b1;
    endfunction

    function automatic void emit_token(t_token_kind k, t_lex_error e,
                                       longint unsigned off, longint unsigned len);
        t_token_exp t;
        t.tok.kind   = k;
        t.tok.err    = e;
        t.tok.offset = clamp_field(off);
        t.tok.length = clamp_field(len);
        t.tok.line   = clamp_field(line_q);
        t.last       = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // a byte seen with no token open
    function automatic void scan_fresh(logic [7:0] c, longint unsigned pos);
        scan_mode_q = SCAN_IDLE;
        if (c == CH_SPACE || c == CH_CR || c == CH_TAB) return;
        if (c == CH_NEWLINE) begin
            bump_line();
            return;
        end
        if (is_letter(c) || is_digit(c) || c == CH_SLASH || c == CH_QUOTE ||
            c == "!" || c == "=" || c == "<" || c == ">") begin
            tok_start_q = POS_BITS'(pos);
            if (is_letter(c))       scan_mode_q = SCAN_IDENT;
            else if (is_digit(c))   scan_mode_q = SCAN_INT;
            else if (c == CH_SLASH) scan_mode_q = SCAN_SLASH;
            else if (c == CH_QUOTE) scan_mode_q = SCAN_STR;
            else begin
                op_char_q   = c;
                scan_mode_q = SCAN_OP;
            end
            return;
        end
        case (c)
            "(":     emit_token(TK_LPAREN, LEX_OK, pos, 1);
            ")":     emit_token(TK_RPAREN, LEX_OK, pos, 1);
            "{":     emit_token(TK_LBRACE, LEX_OK, pos, 1);
            "}":     emit_token(TK_RBRACE, LEX_OK, pos, 1);
            ";":     emit_token(TK_SEMI, LEX_OK, pos, 1);
            ",":     emit_token(TK_COMMA, LEX_OK, pos, 1);
            ".":     emit_token(TK_DOT, LEX_OK, pos, 1);
            "+":     emit_token(TK_PLUS, LEX_OK, pos, 1);
            "*":     emit_token(TK_STAR, LEX_OK, pos, 1);
            default: emit_token(TK_ERROR, LEX_BAD_CHAR, pos, 1);
        endcase
    endfunction

    // tokens completed by one accepted byte or end mark
    function automatic void lex_step(logic [7:0] c, logic eos);
        longint unsigned pos;
        longint unsigned dot;
        pos = byte_pos_q;
        dot = (pos > 0) ? pos - 1 : 0;
        step_tokens.delete();
        if (eos) begin
            case (scan_mode_q)
                SCAN_IDENT: emit_token(TK_IDENT, LEX_OK, tok_start_q, span_to(pos));
                SCAN_INT, SCAN_FRAC: emit_token(TK_NUMBER, LEX_OK, tok_start_q, span_to(pos));
                SCAN_NUMDOT: begin
                    emit_token(TK_NUMBER, LEX_OK, tok_start_q, span_to(dot));
                    emit_token(TK_DOT, LEX_OK, dot, 1);
                end
                SCAN_SLASH: emit_token(TK_SLASH, LEX_OK, tok_start_q, 1);
                SCAN_OP:    emit_token(op_single(op_char_q), LEX_OK, tok_start_q, 1);
                SCAN_STR:   emit_token(TK_ERROR, LEX_OPEN_STRING, tok_start_q, span_to(pos));
                default: ;
            endcase
            emit_token(TK_EOF, LEX_OK, pos, 0);
            scan_mode_q = SCAN_IDLE;
        end else begin
            case (scan_mode_q)
                SCAN_IDENT: begin
                    if (!(is_letter(c) || is_digit(c))) begin
                        emit_token(TK_IDENT, LEX_OK, tok_start_q, span_to(pos));
                        scan_fresh(c, pos);
                    end
                end
                SCAN_INT: begin
                    if (c == CH_DOT) scan_mode_q = SCAN_NUMDOT;
                    else if (!is_digit(c)) begin
                        emit_token(TK_NUMBER, LEX_OK, tok_start_q, span_to(pos));
                        scan_fresh(c, pos);
                    end
                end
                SCAN_NUMDOT: begin
                    if (is_digit(c)) scan_mode_q = SCAN_FRAC;
                    else begin
                        emit_token(TK_NUMBER, LEX_OK, tok_start_q, span_to(dot));
                        emit_token(TK_DOT, LEX_OK, dot, 1);
                        scan_fresh(c, pos);
                    end
                end
                SCAN_FRAC: begin
                    if (!is_digit(c)) begin
                        emit_token(TK_NUMBER, LEX_OK, tok_start_q, span_to(pos));
                        scan_fresh(c, pos);
                    end
                end
                SCAN_SLASH: begin
                    if (c == CH_SLASH) scan_mode_q = SCAN_COMMENT;
                    else begin
                        emit_token(TK_SLASH, LEX_OK, tok_start_q, 1);
                        scan_fresh(c, pos);
                    end
                end
                SCAN_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        bump_line();
                        scan_mode_q = SCAN_IDLE;
                    end
                end
                SCAN_OP: begin
                    // only a following '=' joins the operator
                    if (c == CH_EQUAL) begin
                        emit_token(t_token_kind'(op_single(op_char_q) + 1), LEX_OK,
                                   tok_start_q, 2);
                        scan_mode_q = SCAN_IDLE;
                    end else begin
                        emit_token(op_single(op_char_q), LEX_OK, tok_start_q, 1);
                        scan_fresh(c, pos);
                    end
                end
                SCAN_STR: begin
                    if (c == CH_QUOTE) begin
                        emit_token(TK_STRING, LEX_OK, tok_start_q, span_to(pos + 1));
                        scan_mode_q = SCAN_IDLE;
                    end else if (c == CH_NEWLINE) begin
                        bump_line();
                    end
                end
                default: scan_fresh(c, pos);
            endcase
            if (byte_pos_q != '1) byte_pos_q = byte_pos_q + 1'b1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // one byte transaction, predicted once accepted
    task automatic send_byte(input logic [7:0] c, input logic eos);
        int gap;
        gap = 0;
        if (!quiet_source && $urandom_range(0, 99) < 30) gap = pick_gap();
        if (gap > 0) begin
            src_if.valid         <= 1'b0;
            src_if.char_in       <= 8'($urandom());
            src_if.end_of_source <= 1'($urandom());
            repeat (gap) @(posedge i_clk);
        end
        src_if.valid         <= 1'b1;
        src_if.char_in       <= c;
        src_if.end_of_source <= eos;
        do @(posedge i_clk); while (!src_if.ready);
        lex_step(c, eos);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // one lexical fragment with random content, a bit of noise, or an end mark
    task automatic send_fragment();
        logic [7:0] frag[$];
        logic [7:0] c;
        int         sel;
        int         n;
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
            frag.push_back(pick_char(LETTERS));
            n = $urandom_range(0, 7);
            repeat (n) frag.push_back(pick_char(WORD_CHARS));
        end else if (sel < 36) begin
            n = $urandom_range(1, 5);
            repeat (n) frag.push_back(pick_char(DIGITS));
            if ($urandom_range(0, 9) < 4) begin
                frag.push_back(CH_DOT);
                n = $urandom_range(0, 3);
                repeat (n) frag.push_back(pick_char(DIGITS));
            end
        end else if (sel < 48) begin
            frag.push_back(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                c = 8'($urandom_range(32, 126));
                if (c == CH_QUOTE) c = "q";
                if ($urandom_range(0, 6) == 0) c = CH_NEWLINE;
                frag.push_back(c);
            end
            if ($urandom_range(0, 9) != 0) frag.push_back(CH_QUOTE);
        end else if (sel < 56) begin
            frag.push_back(CH_SLASH);
            frag.push_back(CH_SLASH);
            n = $urandom_range(0, 6);
            repeat (n) frag.push_back(8'($urandom_range(32, 126)));
            frag.push_back(CH_NEWLINE);
        end else if (sel < 70) begin
            frag.push_back(pick_char(OPS));
            if ($urandom_range(0, 1) == 1) frag.push_back(CH_EQUAL);
        end else if (sel < 82) begin
            frag.push_back(pick_char(PUNCT));
        end else if (sel < 92) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       frag.push_back(CH_SPACE);
                    1:       frag.push_back(CH_TAB);
                    2:       frag.push_back(CH_CR);
                    default: frag.push_back(CH_NEWLINE);
                endcase
            end
        end else if (sel < 97) begin
            n = $urandom_range(1, 2);
            repeat (n) frag.push_back(8'($urandom_range(0, 255)));
        end
        if (sel >= 97) send_byte(8'($urandom()), 1'b1);
        else foreach (frag[i]) send_byte(frag[i], 1'b0);
    endtask

    // every single and two-character operator, every punctuation mark but the slash
    task automatic test_operators();
        send_text("(){};,.+*!<=>!====<>=");
    endtask

    // dot after digits with three tokens from one byte, minus-led identifier,
    // extreme bytes, a string left open at the end mark, repeated end mark
    task automatic test_special_cases();
        send_text("7.(-z9 ");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_text("a");
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // sink holds off while runs of 7.( keep coming, each ending in a byte that finishes three tokens
    task automatic test_sink_backpressure();
        sink_hold_req = 1;
        quiet_source  = 1;
        repeat (10) send_text("7.(");
        quiet_source  = 0;
    endtask

    task automatic test_random_text();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_ITEMS) begin
            quiet_source = ($urandom_range(0, 9) == 0);
            quiet_sink   = ($urandom_range(0, 9) == 0);
            send_fragment();
        end
        quiet_source = 0;
        quiet_sink   = 0;
        send_byte(8'($urandom()), 1'b1);
    endtask

    // token sink with random stalls and the long hold-off on request
    initial begin : token_sink
        int stall_left;
        stall_left = 0;
        tok_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                tok_if.ready <= 1'b0;
            end else if (!quiet_sink && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap() - 1;
                tok_if.ready <= 1'b0;
            end else begin
                tok_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // compare each token transaction with the oldest prediction
    always @(posedge i_clk) begin : token_check
        t_token_exp want;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            if (expected_tokens.size() == 0) begin
                $error("token with nothing expected: kind %0d offset %0d",
                       tok_if.token_kind, tok_if.token_offset);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.tok.kind, tok_if.token_kind);
                check_field("error_kind", want.tok.err, tok_if.error_kind);
                check_field("token_offset", want.tok.offset, tok_if.token_offset);
                check_field("token_length", want.tok.length, tok_if.token_length);
                check_field("line_number", want.tok.line, tok_if.line_number);
                check_field("last_of_run", want.last, tok_if.last_of_run);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        src_if.valid         <= 1'b0;
        src_if.char_in       <= '0;
        src_if.end_of_source <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_operators();
        test_special_cases();
        test_sink_backpressure();
        test_random_text();

        // drain outstanding tokens, then watch for strays
        src_if.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
